@@ rtl/rdq_pkg.sv @@
`timescale 1ns / 1ps
package rdq_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_READ_AT    = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_INS_RD,
    S_INS_WR,
    S_INS_FIN,
    S_REM_RD,
    S_REM_WR
  } state_e;

endpackage

@@ rtl/rdq_ram.sv @@
`timescale 1ns / 1ps
module rdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ring_deque_with_indexed_insert_core.sv @@
`timescale 1ns / 1ps
// Double-ended queue of up to DEPTH words in a ring held in one RAM with a
// registered read. A command is taken when start is high and busy is low;
// its result comes back on status_o, data_out_o and fill_count_o in the one
// cycle where done_o is high, and must be taken then since the receiver
// cannot stall. Push, clear, insert at the back end and any rejected command
// answer the cycle after start. Pop and read at an index need one RAM read
// and answer from S_RD_WAIT after the registered read. Insert at a clamped
// index p below the count shifts words from p up (S_INS_RD, S_INS_WR), then
// writes the new word (S_INS_FIN); remove of n words at p shifts later words
// down (S_REM_RD, S_REM_WR) and answers the cycle after start when nothing
// moves. Each moved word takes one RAM read and one RAM write through the
// single read port. Busy is high from the cycle after start until the answer
// cycle, so the next command can start in the cycle where done_o is high.
module ring_deque_with_indexed_insert_core import rdq_pkg::*; #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [CNT_W-1:0]  remove_count_i,
  input  logic [WORD_W-1:0] data_in_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [WORD_W-1:0] data_out_o,
  output logic [CNT_W-1:0]  fill_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CNT_W) ? CW : CNT_W;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(DEPTH) - (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [AW-1:0]        front_q, front_d;
  logic [AW-1:0]        back_q, back_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        num_q, num_d;
  logic [ELEM_BITS-1:0] data_q, data_d;
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [WORD_W-1:0]    dout_q, dout_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ELEM_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ELEM_BITS-1:0] ram_rdata;

  logic [XW-1:0]        pos_x, cnt_x, num_x, rem_x;
  logic [CW-1:0]        pos_clamp, num_clamp;
  logic                 full, empty;
  logic [AW-1:0]        slot_tmp;

  rdq_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign pos_x     = XW'(position_i);
  assign cnt_x     = XW'(count_q);
  assign num_x     = XW'(remove_count_i);
  assign rem_x     = cnt_x - pos_x;
  assign pos_clamp = (pos_x > cnt_x) ? count_q : CW'(pos_x);
  assign num_clamp = (num_x > rem_x) ? CW'(rem_x) : CW'(num_x);

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    num_d     = num_q;
    data_d    = data_q;
    done_d    = 1'b0;
    status_d  = status_q;
    dout_d    = dout_q;
    ram_we    = 1'b0;
    ram_waddr = back_q;
    ram_wdata = data_q;
    ram_raddr = front_q;
    slot_tmp  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          data_d   = ELEM_BITS'(data_in_i);
          done_d   = 1'b1;
          status_d = ST_OK;
          dout_d   = '0;
          case (op_e'(opcode_i))
            OP_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_q;
                ram_wdata = ELEM_BITS'(data_in_i);
                back_d    = wrap_add(back_q, CW'(1));
                count_d   = count_q + CW'(1);
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                slot_tmp  = wrap_sub(front_q, CW'(1));
                ram_we    = 1'b1;
                ram_waddr = slot_tmp;
                ram_wdata = ELEM_BITS'(data_in_i);
                front_d   = slot_tmp;
                count_d   = count_q + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                slot_tmp  = wrap_sub(back_q, CW'(1));
                ram_raddr = slot_tmp;
                back_d    = slot_tmp;
                count_d   = count_q - CW'(1);
                done_d    = 1'b0;
                state_d   = S_RD_WAIT;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                ram_raddr = front_q;
                front_d   = wrap_add(front_q, CW'(1));
                count_d   = count_q - CW'(1);
                done_d    = 1'b0;
                state_d   = S_RD_WAIT;
              end
            end
            OP_INSERT_AT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (count_q > pos_clamp) begin
                pos_d   = pos_clamp;
                idx_d   = count_q;
                done_d  = 1'b0;
                state_d = S_INS_RD;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(front_q, pos_clamp);
                ram_wdata = ELEM_BITS'(data_in_i);
                back_d    = wrap_add(back_q, CW'(1));
                count_d   = count_q + CW'(1);
              end
            end
            OP_REMOVE_AT: begin
              if (pos_x >= cnt_x) begin
                status_d = ST_EMPTY;
              end else if (CW'(pos_x) + num_clamp < count_q) begin
                pos_d   = CW'(pos_x);
                num_d   = num_clamp;
                idx_d   = CW'(pos_x);
                done_d  = 1'b0;
                state_d = S_REM_RD;
              end else begin
                count_d = count_q - num_clamp;
                back_d  = wrap_sub(back_q, num_clamp);
              end
            end
            OP_READ_AT: begin
              if (pos_x >= cnt_x) begin
                status_d = ST_EMPTY;
              end else begin
                ram_raddr = wrap_add(front_q, CW'(pos_x));
                done_d    = 1'b0;
                state_d   = S_RD_WAIT;
              end
            end
            OP_CLEAR: begin
              front_d = '0;
              back_d  = '0;
              count_d = '0;
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        dout_d   = WORD_W'(ram_rdata);
        state_d  = S_IDLE;
      end
      S_INS_RD: begin
        ram_raddr = wrap_add(front_q, idx_q - CW'(1));
        state_d   = S_INS_WR;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(front_q, idx_q);
        ram_wdata = ram_rdata;
        idx_d     = idx_q - CW'(1);
        state_d   = ((idx_q - CW'(1)) == pos_q) ? S_INS_FIN : S_INS_RD;
      end
      S_INS_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(front_q, pos_q);
        ram_wdata = data_q;
        back_d    = wrap_add(back_q, CW'(1));
        count_d   = count_q + CW'(1);
        done_d    = 1'b1;
        status_d  = ST_OK;
        dout_d    = '0;
        state_d   = S_IDLE;
      end
      S_REM_RD: begin
        ram_raddr = wrap_add(front_q, idx_q + num_q);
        state_d   = S_REM_WR;
      end
      S_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(front_q, idx_q);
        ram_wdata = ram_rdata;
        idx_d     = idx_q + CW'(1);
        if (idx_q + CW'(1) + num_q < count_q) begin
          state_d = S_REM_RD;
        end else begin
          count_d  = count_q - num_q;
          back_d   = wrap_sub(back_q, num_q);
          done_d   = 1'b1;
          status_d = ST_OK;
          dout_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      dout_q   <= '0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      dout_q   <= dout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    num_q  <= num_d;
    data_q <= data_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign data_out_o   = dout_q;
  assign fill_count_o = CNT_W'(count_q);

endmodule

@@ rtl/rdq_checker.sv @@
`timescale 1ns / 1ps
module rdq_checker import rdq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [OP_W-1:0]   opcode_i,
  input logic              done_o,
  input logic [STAT_W-1:0] status_o,
  input logic [WORD_W-1:0] data_out_o,
  input logic [CNT_W-1:0]  fill_count_o
);

  // a result only shows once the command is finished
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_EMPTY))
    else $error("undefined status code");

  // rejected commands carry no word
  a_fail_no_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (data_out_o == '0))
    else $error("word on a failed command");

  a_push_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_PUSH_BACK || opcode_i == OP_PUSH_FRONT))
      |=> (done_o && status_o != ST_EMPTY && data_out_o == '0))
    else $error("push did not answer in one cycle");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_CLEAR)
      |=> (done_o && status_o == ST_OK && fill_count_o == '0))
    else $error("clear did not empty the queue");

endmodule

bind ring_deque_with_indexed_insert_core rdq_checker u_rdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .opcode_i     (opcode_i),
  .done_o       (done_o),
  .status_o     (status_o),
  .data_out_o   (data_out_o),
  .fill_count_o (fill_count_o)
);
